// File: design/per_port_queue_round_robin_shaper_macros.svh
// Assertion helpers for the shaper's RTL.
`ifndef PER_PORT_QUEUE_ROUND_ROBIN_SHAPER_MACROS_SVH
`define PER_PORT_QUEUE_ROUND_ROBIN_SHAPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPRRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shaper check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPRRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shaper check failed");

`endif

// File: design/pprrs_pkg.sv
`timescale 1ns / 1ps

package pprrs_pkg;

    localparam int unsigned HANDLE_W     = 16;
    localparam int unsigned PORT_FIELD_W = 2;
    localparam int unsigned EVENT_W      = 2;
    localparam int unsigned LIMIT_W      = 5;
    localparam int unsigned PERIOD_W     = 16;
    localparam int unsigned CFG_INDEX_W  = 1;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [EVENT_W-1:0] EV_ACCEPT    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DROP      = 2'd1;
    localparam logic [EVENT_W-1:0] EV_TICK_IDLE = 2'd2;
    localparam logic [EVENT_W-1:0] EV_TICK_SEND = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LIMIT     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPATCH_PERIOD = 1'b1;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;       // latch the accepted input transaction
        logic exec;          // apply the item to queue and timer state
        logic out_load;      // load the output register
        logic out_from_mem;  // output comes from a queue pop
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_req;   // captured tick expires on a non-empty queue
        logic out_free;  // output register can take a new result this cycle
    } t_dp_status;

endpackage

// File: design/pprrs_ctrl.sv
`timescale 1ns / 1ps

module pprrs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  pprrs_pkg::t_dp_status i_status,
    output pprrs_pkg::t_ctl_cmd   o_cmd,
    output logic                  o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                // The stall flag is set by reset, so it also keeps the input closed right after reset.
                if (i_in_valid && !r_in_stall) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // A pop goes through S_READ for the registered queue read.
                if (i_status.pop_req) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_READ;
                end else if (i_status.out_free) begin
                    o_cmd.exec     = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_READ: begin
                if (i_status.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_from_mem = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// File: design/pprrs_dp.sv
`timescale 1ns / 1ps

module pprrs_dp #(
    parameter int unsigned NUM_PORTS   = 4,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pprrs_pkg::t_ctl_cmd                   i_cmd,
    output pprrs_pkg::t_dp_status                 o_status,
    input  logic                                  i_op,
    input  logic [pprrs_pkg::PORT_FIELD_W-1:0]    i_in_port,
    input  logic [pprrs_pkg::HANDLE_W-1:0]        i_packet_handle,
    input  logic                                  i_cfg_we,
    input  logic [pprrs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [pprrs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [pprrs_pkg::EVENT_W-1:0]         o_event_res,
    output logic [pprrs_pkg::PORT_FIELD_W-1:0]    o_out_port,
    output logic [pprrs_pkg::HANDLE_W-1:0]        o_out_packet
);

    localparam int unsigned PW  = $clog2(NUM_PORTS);
    localparam int unsigned SW  = $clog2(QUEUE_DEPTH);
    localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PXW = (PW + 1 > pprrs_pkg::PORT_FIELD_W) ?
                                  PW + 1 : pprrs_pkg::PORT_FIELD_W;
    localparam int unsigned CW  = (FW > pprrs_pkg::LIMIT_W) ? FW : pprrs_pkg::LIMIT_W;

    // Captured item.
    logic                                r_op;
    logic [pprrs_pkg::PORT_FIELD_W-1:0]  r_port;
    logic [pprrs_pkg::HANDLE_W-1:0]      r_handle;

    // Configuration.
    logic [pprrs_pkg::LIMIT_W-1:0]       r_limit;
    logic [pprrs_pkg::PERIOD_W-1:0]      r_period;

    // Queue bookkeeping and dispatch timer.
    logic [SW-1:0]                       r_head [NUM_PORTS];
    logic [FW-1:0]                       r_fill [NUM_PORTS];
    logic [PW-1:0]                       r_rotor;
    logic                                r_timer_on;
    logic [pprrs_pkg::PERIOD_W-1:0]      r_countdown;
    logic [PW-1:0]                       r_pop_port;

    // Packet handle storage, one row per port.
    logic [pprrs_pkg::HANDLE_W-1:0]      mem [NUM_PORTS][QUEUE_DEPTH];
    logic [pprrs_pkg::HANDLE_W-1:0]      r_rdata;

    logic                                r_out_valid;
    logic [pprrs_pkg::EVENT_W-1:0]       r_out_res;
    logic [pprrs_pkg::PORT_FIELD_W-1:0]  r_out_port;
    logic [pprrs_pkg::HANDLE_W-1:0]      r_out_pkt;

    logic [PXW-1:0]                      w_port_ext;
    logic [PW-1:0]                       w_arr_idx;
    logic                                w_port_ok;
    logic [FW-1:0]                       w_arr_fill;
    logic                                w_arrival_ok;
    logic [SW:0]                         w_tail_sum;
    logic [SW-1:0]                       w_tail;
    logic [FW-1:0]                       w_rot_fill;
    logic                                w_expire;
    logic                                w_pop;
    logic [pprrs_pkg::EVENT_W-1:0]       w_res_now;
    logic [PW-1:0]                       w_rotor_next;
    logic [SW-1:0]                       w_head_next;
    logic [PXW-1:0]                      w_pop_port_ext;
    logic                                w_out_free;
    logic                                w_arrival_write;

    always_comb begin
        w_port_ext   = PXW'(r_port);
        w_port_ok    = (w_port_ext < PXW'(NUM_PORTS));
        w_arr_idx    = w_port_ext[PW-1:0];
        w_arr_fill   = r_fill[w_arr_idx];
        w_arrival_ok = w_port_ok && (CW'(w_arr_fill) < CW'(r_limit)) &&
                       (w_arr_fill < FW'(QUEUE_DEPTH));
        // Occupied slots are below the depth, so one subtract wraps the tail.
        w_tail_sum   = (SW + 1)'(r_head[w_arr_idx]) + (SW + 1)'(w_arr_fill);
        if (w_tail_sum >= (SW + 1)'(QUEUE_DEPTH)) begin
            w_tail_sum = w_tail_sum - (SW + 1)'(QUEUE_DEPTH);
        end
        w_tail       = w_tail_sum[SW-1:0];

        w_rot_fill   = r_fill[r_rotor];
        w_expire     = r_timer_on && (r_countdown <= pprrs_pkg::PERIOD_W'(1));
        w_pop        = (r_op == pprrs_pkg::OP_TICK) && w_expire && (w_rot_fill != '0);
        w_rotor_next = (r_rotor == PW'(NUM_PORTS - 1)) ? '0 : r_rotor + PW'(1);
        w_head_next  = (r_head[r_rotor] == SW'(QUEUE_DEPTH - 1)) ?
                       '0 : r_head[r_rotor] + SW'(1);

        if (r_op == pprrs_pkg::OP_ARRIVAL) begin
            w_res_now = w_arrival_ok ? pprrs_pkg::EV_ACCEPT : pprrs_pkg::EV_DROP;
        end else begin
            w_res_now = pprrs_pkg::EV_TICK_IDLE;
        end

        w_pop_port_ext  = PXW'(r_pop_port);
        w_out_free      = !r_out_valid || !i_out_stall;
        w_arrival_write = i_cmd.exec && (r_op == pprrs_pkg::OP_ARRIVAL) && w_arrival_ok;
    end

    assign o_status.pop_req  = w_pop;
    assign o_status.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_port   <= i_in_port;
            r_handle <= i_packet_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= pprrs_pkg::LIMIT_RESET;
            r_period <= pprrs_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pprrs_pkg::CFG_QUEUE_LIMIT:
                    r_limit <= i_cfg_data[pprrs_pkg::LIMIT_W-1:0];
                pprrs_pkg::CFG_DISPATCH_PERIOD:
                    r_period <= i_cfg_data[pprrs_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
            r_rotor     <= '0;
            r_timer_on  <= 1'b0;
            r_countdown <= '0;
        end else if (i_cmd.exec) begin
            if (r_op == pprrs_pkg::OP_ARRIVAL) begin
                if (w_arrival_ok) begin
                    r_fill[w_arr_idx] <= w_arr_fill + FW'(1);
                end
                if (!r_timer_on) begin
                    r_timer_on  <= 1'b1;
                    r_countdown <= r_period;
                end
            end else if (r_timer_on) begin
                if (w_expire) begin
                    if (w_pop) begin
                        r_head[r_rotor] <= w_head_next;
                        r_fill[r_rotor] <= w_rot_fill - FW'(1);
                    end
                    r_rotor     <= w_rotor_next;
                    r_countdown <= r_period;
                end else begin
                    r_countdown <= r_countdown - pprrs_pkg::PERIOD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_arrival_write) begin
            mem[w_arr_idx][w_tail] <= r_handle;
        end
        if (i_cmd.exec && w_pop) begin
            r_rdata    <= mem[r_rotor][r_head[r_rotor]];
            r_pop_port <= r_rotor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_from_mem) begin
                r_out_res  <= pprrs_pkg::EV_TICK_SEND;
                r_out_port <= w_pop_port_ext[pprrs_pkg::PORT_FIELD_W-1:0];
                r_out_pkt  <= r_rdata;
            end else begin
                r_out_res  <= w_res_now;
                r_out_port <= '0;
                r_out_pkt  <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_out_res;
    assign o_out_port   = r_out_port;
    assign o_out_packet = r_out_pkt;

endmodule

// File: design/per_port_queue_round_robin_shaper.sv
`timescale 1ns / 1ps
// Per-port packet queue with a round-robin leaky-bucket dispatcher.
// Input channel (i_in_valid / o_in_stall) carries one transaction per item:
// an arrival (i_op = 0) queues i_packet_handle on port i_in_port, or a time
// tick (i_op = 1) advances the dispatch timer. Every item yields exactly one
// result transaction on the output channel (o_out_valid / i_out_stall):
// accepted, dropped, tick without send, or tick with the sent port and handle.
// Items are handled one at a time. An arrival or a tick that sends nothing
// is loaded into the output register from S_EXEC after acceptance; a tick that
// pops a queue passes through S_READ as well, for the registered handle read.
// The next item is accepted only after the result is loaded and the controller
// is back in S_IDLE, so the block takes no new item while one is in flight.
// The output register holds a finished result while the receiver stalls; the
// controller keeps working up to the point of loading the next result.
// Configuration (i_cfg_*) is always ready and takes effect at once; index 0
// is the per-queue limit, index 1 the dispatch period in ticks.
// Reset clears all queues, the rotor and the timer, restores the limit to
// 16 and the period to 1, and holds the input stalled until the controller's
// stall flag first updates after release; the handle memory itself is not cleared.

`include "per_port_queue_round_robin_shaper_macros.svh"

module per_port_queue_round_robin_shaper #(
    parameter int unsigned NUM_PORTS   = 4,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [pprrs_pkg::PORT_FIELD_W-1:0]  i_in_port,
    input  logic [pprrs_pkg::HANDLE_W-1:0]      i_packet_handle,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pprrs_pkg::EVENT_W-1:0]       o_event_res,
    output logic [pprrs_pkg::PORT_FIELD_W-1:0]  o_out_port,
    output logic [pprrs_pkg::HANDLE_W-1:0]      o_out_packet,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pprrs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pprrs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pprrs_pkg::t_ctl_cmd   w_cmd;
    pprrs_pkg::t_dp_status w_status;
    logic                  w_in_accept;

    // Registers are plain flops, so a configuration write never waits.
    assign o_cfg_ready = 1'b1;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // The controller sequences capture, state update and result loading.
    pprrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath owns the queues, the handle memory, the timer and the
    // output register.
    pprrs_dp #(
        .NUM_PORTS   (NUM_PORTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_op            (i_op),
        .i_in_port       (i_in_port),
        .i_packet_handle (i_packet_handle),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_event_res     (o_event_res),
        .o_out_port      (o_out_port),
        .o_out_packet    (o_out_packet)
    );

    // An accepted transaction must close the input until its result is loaded.
    `PPRRS_ASSERT_NEXT(a_accept_closes_input, i_clk, i_rst_n, w_in_accept, o_in_stall)
    // A result is loaded only when the output register can take it.
    `PPRRS_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, w_status.out_free)
    // The capture command fires exactly on an input acceptance.
    `PPRRS_ASSERT_NOW(a_capture_matches_accept, i_clk, i_rst_n, w_cmd.capture, w_in_accept)
    // Output valid only rises after a load command.
    `PPRRS_ASSERT_NOW(a_valid_from_load, i_clk, i_rst_n, $rose(o_out_valid), $past(w_cmd.out_load))

endmodule

// File: tb/per_port_queue_round_robin_shaper_tb.sv
`timescale 1ns / 1ps

module per_port_queue_round_robin_shaper_tb;

    localparam int unsigned PORTS       = 4;
    localparam int unsigned DEPTH       = 16;
    // The slowest correct run is about 1900 transactions, each slowed by the
    // block's own states, idle gaps on the sender side and receiver stalls.
    // The limit leaves a wide margin above that run.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Room for every expected result of the run.
    localparam int unsigned EXP_SLOTS   = 4096;

    // One result transaction as the output channel presents it.
    typedef struct packed {
        logic [pprrs_pkg::EVENT_W-1:0]      ev;
        logic [pprrs_pkg::PORT_FIELD_W-1:0] port;
        logic [pprrs_pkg::HANDLE_W-1:0]     pkt;
    } t_shaper_event;

    // Receiver behavior. The mode is redrawn at random from time to time, so that
    // stalls land on every phase of the block's work.
    typedef enum int unsigned {
        STALL_NONE,
        STALL_RANDOM,
        STALL_LONG,
        STALL_TOGGLE
    } t_stall_mode;

    logic                               i_clk           = 1'b0;
    logic                               i_rst_n         = 1'b0;
    logic                               i_in_valid      = 1'b0;
    logic                               o_in_stall;
    logic                               i_op            = pprrs_pkg::OP_ARRIVAL;
    logic [pprrs_pkg::PORT_FIELD_W-1:0] i_in_port       = '0;
    logic [pprrs_pkg::HANDLE_W-1:0]     i_packet_handle = '0;
    logic                               o_out_valid;
    logic                               i_out_stall     = 1'b0;
    logic [pprrs_pkg::EVENT_W-1:0]      o_event_res;
    logic [pprrs_pkg::PORT_FIELD_W-1:0] o_out_port;
    logic [pprrs_pkg::HANDLE_W-1:0]     o_out_packet;
    logic                               i_cfg_valid     = 1'b0;
    logic                               o_cfg_ready;
    logic [pprrs_pkg::CFG_INDEX_W-1:0]  i_cfg_index     = pprrs_pkg::CFG_QUEUE_LIMIT;
    logic [pprrs_pkg::CFG_DATA_W-1:0]   i_cfg_data      = '0;

    per_port_queue_round_robin_shaper #(
        .NUM_PORTS   (PORTS),
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_in_port       (i_in_port),
        .i_packet_handle (i_packet_handle),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_res     (o_event_res),
        .o_out_port      (o_out_port),
        .o_out_packet    (o_out_packet),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the shaper state, kept in step with every transaction
    // that the block accepts.
    logic [pprrs_pkg::HANDLE_W-1:0]  queue_mirror [PORTS][DEPTH];
    logic [3:0]                      head_mirror  [PORTS];
    logic [4:0]                      fill_mirror  [PORTS];
    logic [1:0]                      rotor_mirror;
    logic                            timer_on_mirror;
    logic [pprrs_pkg::PERIOD_W-1:0]  countdown_mirror;
    logic [pprrs_pkg::LIMIT_W-1:0]   limit_mirror;
    logic [pprrs_pkg::PERIOD_W-1:0]  period_mirror;

    // Expected results in order; the sender writes at exp_wr and the checker
    // reads at exp_rd.
    t_shaper_event expected_events [EXP_SLOTS];
    int unsigned   exp_wr = 0;
    int unsigned   exp_rd = 0;
    t_shaper_event oldest_event;
    int unsigned   mismatches = 0;
    int unsigned   cycle_count = 0;
    int unsigned   burst_left = 0;
    t_stall_mode   stall_mode = STALL_NONE;
    int unsigned   mode_cycles = 0;
    int unsigned   stall_run = 0;

    function automatic int unsigned pending_count();
        return exp_wr - exp_rd;
    endfunction

    // Works out the result of one transaction and advances the shadow state.
    // The port field is two bits wide, so every arrival port is a real port.
    function automatic t_shaper_event predict_event(
            input logic op,
            input logic [pprrs_pkg::PORT_FIELD_W-1:0] port,
            input logic [pprrs_pkg::HANDLE_W-1:0] handle);
        t_shaper_event r;
        logic [4:0]    cap;
        logic [3:0]    tail;
        logic [1:0]    q;
        r = '0;
        // A limit above the queue depth acts as the depth itself.
        cap = (limit_mirror > DEPTH) ? 5'(DEPTH) : limit_mirror;
        if (op == pprrs_pkg::OP_ARRIVAL) begin
            if (fill_mirror[port] < cap) begin
                tail = head_mirror[port] + fill_mirror[port][3:0];
                queue_mirror[port][tail] = handle;
                fill_mirror[port] = fill_mirror[port] + 5'd1;
                r.ev = pprrs_pkg::EV_ACCEPT;
            end else begin
                r.ev = pprrs_pkg::EV_DROP;
            end
            // Any arrival, dropped or not, starts the timer exactly once.
            if (!timer_on_mirror) begin
                timer_on_mirror  = 1'b1;
                countdown_mirror = period_mirror;
            end
        end else begin
            r.ev = pprrs_pkg::EV_TICK_IDLE;
            if (timer_on_mirror) begin
                // A countdown of zero, from a zero period, expires at once.
                if (countdown_mirror <= 1) begin
                    q = rotor_mirror;
                    if (fill_mirror[q] != 0) begin
                        r.ev   = pprrs_pkg::EV_TICK_SEND;
                        r.port = q;
                        r.pkt  = queue_mirror[q][head_mirror[q]];
                        head_mirror[q] = head_mirror[q] + 4'd1;
                        fill_mirror[q] = fill_mirror[q] - 5'd1;
                    end
                    rotor_mirror     = q + 2'd1;
                    countdown_mirror = period_mirror;
                end else begin
                    countdown_mirror = countdown_mirror - pprrs_pkg::PERIOD_W'(1);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h, cycle %0d",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // Result checker. Outputs are read at the rising edge, before the block's
    // registers update, so each read sees the values the edge sampled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_count() == 0) begin
                report_mismatch("result with no transaction pending", o_event_res, 0);
            end else begin
                oldest_event = expected_events[exp_rd % EXP_SLOTS];
                exp_rd++;
                if (o_event_res !== oldest_event.ev)
                    report_mismatch("event_res", o_event_res, oldest_event.ev);
                if (o_out_port !== oldest_event.port)
                    report_mismatch("out_port", o_out_port, oldest_event.port);
                if (o_out_packet !== oldest_event.pkt)
                    report_mismatch("out_packet", o_out_packet, oldest_event.pkt);
            end
        end
    end

    // The receiver stalls in runs of different shapes, including stretches
    // with no stall at all.
    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            stall_mode  <= t_stall_mode'($urandom_range(0, 3));
            mode_cycles <= $urandom_range(50, 300);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_out_stall <= 1'($urandom_range(0, 1));
            end
            STALL_LONG: begin
                if (stall_run != 0) begin
                    i_out_stall <= 1'b1;
                    stall_run   <= stall_run - 1;
                end else if ($urandom_range(0, 15) == 0) begin
                    i_out_stall <= 1'b1;
                    stall_run   <= $urandom_range(5, 20);
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
            default: begin
                i_out_stall <= ~i_out_stall;
            end
        endcase
    end

    // Watchdog for a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Sends one transaction on the input channel. The sender works in bursts
    // of random length, with an idle gap of random length between bursts.
    // The task is entered at a rising edge and returns at the edge that
    // accepted the transaction, with valid still high, so that back-to-back
    // transactions never lower and raise valid within one time step.
    task automatic send_item(input logic op,
                             input logic [pprrs_pkg::PORT_FIELD_W-1:0] port,
                             input logic [pprrs_pkg::HANDLE_W-1:0] handle);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_in_port       <= port;
        i_packet_handle <= handle;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_events[exp_wr % EXP_SLOTS] = predict_event(op, port, handle);
        exp_wr++;
    endtask

    task automatic send_random_item(input int unsigned arrival_pct);
        logic op;
        op = ($urandom_range(0, 99) < arrival_pct) ? pprrs_pkg::OP_ARRIVAL :
                                                     pprrs_pkg::OP_TICK;
        // Port and handle are random on ticks too, where the block ignores them.
        send_item(op, pprrs_pkg::PORT_FIELD_W'($urandom_range(0, PORTS - 1)),
                  pprrs_pkg::HANDLE_W'($urandom));
    endtask

    // Holds the sender off until every predicted result has been seen.
    task automatic wait_until_drained;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write. Valid is left high so that a following write can
    // keep it up; the caller lowers it after the last write.
    task automatic cfg_write(input logic [pprrs_pkg::CFG_INDEX_W-1:0] index,
                             input logic [pprrs_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == pprrs_pkg::CFG_QUEUE_LIMIT)
            limit_mirror = data[pprrs_pkg::LIMIT_W-1:0];
        else
            period_mirror = data[pprrs_pkg::PERIOD_W-1:0];
    endtask

    // Registers are only written once the block has gone idle.
    task automatic configure(input logic [pprrs_pkg::LIMIT_W-1:0] limit,
                             input logic [pprrs_pkg::PERIOD_W-1:0] period);
        wait_until_drained();
        cfg_write(pprrs_pkg::CFG_QUEUE_LIMIT, pprrs_pkg::CFG_DATA_W'(limit));
        cfg_write(pprrs_pkg::CFG_DISPATCH_PERIOD, period);
        i_cfg_valid <= 1'b0;
    endtask

    // Before any arrival the timer is stopped, so a tick sends nothing.
    task automatic test_tick_before_start;
        send_item(pprrs_pkg::OP_TICK, 2'd3, 16'hFFFF);
    endtask

    // With a limit of zero the first arrival is dropped, yet it still starts
    // the timer. A zero period then opens a dispatch slot on every tick, here
    // on empty queues.
    task automatic test_drop_starts_timer;
        configure(5'd0, 16'd0);
        send_item(pprrs_pkg::OP_ARRIVAL, 2'd0, 16'h0001);
        send_item(pprrs_pkg::OP_TICK, 2'd0, 16'h0000);
        send_item(pprrs_pkg::OP_TICK, 2'd1, 16'h0000);
    endtask

    // A limit above the queue depth, extreme handles on every port, then
    // enough ticks at a period of two for the rotor to visit each port.
    task automatic test_field_extremes;
        configure(5'd31, 16'd2);
        send_item(pprrs_pkg::OP_ARRIVAL, 2'd0, 16'h0000);
        send_item(pprrs_pkg::OP_ARRIVAL, 2'd3, 16'hFFFF);
        send_item(pprrs_pkg::OP_ARRIVAL, 2'd1, 16'h1234);
        send_item(pprrs_pkg::OP_ARRIVAL, 2'd2, 16'hA5A5);
        repeat (8) send_item(pprrs_pkg::OP_TICK, 2'd0, 16'h0000);
    endtask

    // With a limit of one, a second arrival on the same port is dropped.
    task automatic test_limit_reached;
        configure(5'd1, 16'd1);
        send_item(pprrs_pkg::OP_ARRIVAL, 2'd2, 16'h5A5A);
        send_item(pprrs_pkg::OP_ARRIVAL, 2'd2, 16'hC3C3);
        repeat (4) send_item(pprrs_pkg::OP_TICK, 2'd0, 16'h0000);
    endtask

    // Phases of random traffic, each with its own limit, period and mix of
    // arrivals and ticks. Heavy arrival phases fill the queues up to the
    // limit; light ones let the rotor pass over empty queues.
    task automatic test_random_phases;
        logic [pprrs_pkg::LIMIT_W-1:0]  limits  [8];
        logic [pprrs_pkg::PERIOD_W-1:0] periods [8];
        int unsigned                    mix     [8];
        limits  = '{5'd16, 5'd31, 5'd1, 5'd4, 5'd0, 5'd8, 5'd2,
                    pprrs_pkg::LIMIT_W'($urandom_range(0, 31))};
        periods = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd3, 16'd5, 16'd1,
                    pprrs_pkg::PERIOD_W'($urandom_range(0, 7))};
        mix     = '{50, 70, 40, 60, 50, 55, 65, 50};
        for (int p = 0; p < 8; p++) begin
            configure(limits[p], periods[p]);
            repeat (210) send_random_item(mix[p]);
        end
    endtask

    // The sender stops mid-stream until every result has come back, then
    // carries on with the same settings.
    task automatic test_pause_until_drained;
        configure(5'd16, 16'd1);
        repeat (40) send_random_item(60);
        wait_until_drained();
        repeat (40) send_random_item(60);
    endtask

    // The longest period, then a fully random one. Once a slot reloads the
    // countdown it rarely expires again, so these phases run last.
    task automatic test_long_period;
        configure(5'd17, 16'hFFFF);
        repeat (60) send_random_item(80);
        configure(pprrs_pkg::LIMIT_W'($urandom_range(0, 31)),
                  pprrs_pkg::PERIOD_W'($urandom));
        repeat (60) send_random_item(50);
    endtask

    initial begin
        for (int p = 0; p < PORTS; p++) begin
            head_mirror[p] = '0;
            fill_mirror[p] = '0;
        end
        rotor_mirror     = '0;
        timer_on_mirror  = 1'b0;
        countdown_mirror = '0;
        limit_mirror     = pprrs_pkg::LIMIT_RESET;
        period_mirror    = pprrs_pkg::PERIOD_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tick_before_start();
        test_drop_starts_timer();
        test_field_extremes();
        test_limit_reached();
        test_random_phases();
        test_pause_until_drained();
        test_long_period();

        wait_until_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_count() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
